FILE: rtl/assert_macros.svh
// assertion macros for the lattice offset pair match rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent at an edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/lopm_pkg.sv
// shared constants and types of the lattice offset pair match block
package lopm_pkg;

  localparam int COMP_WIDTH_DEF = 20;
  localparam int FRAC_BITS_DEF  = 12;

  localparam int SCALE_W     = 20;
  localparam int SCALE_FRAC  = 12;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd4096;

  localparam int L_SAT_BITS  = 40;
  localparam int DA_SAT_BITS = 40;
  localparam int DF_SAT_BITS = 30;
  localparam int IDX_W       = 16;
  localparam int ERR_W       = 40;
  localparam int CORNERS     = 4;
  localparam int PAIRS       = 16;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int REG_LATTICE_SCALE = 0;

  typedef struct packed {
    logic ovf;
    logic rnz;
  } div_stat_t;

endpackage

FILE: rtl/lopm_if.sv
// item channels of the lattice offset pair match block
interface lopm_in_if import lopm_pkg::*; #(parameter int COMP_WIDTH = COMP_WIDTH_DEF);
  logic valid;
  logic ready;
  logic [3*COMP_WIDTH-1:0] vertex_a;
  logic [3*COMP_WIDTH-1:0] normal_a;
  logic [3*COMP_WIDTH-1:0] tangent_a;
  logic [3*COMP_WIDTH-1:0] bitangent_a;
  logic [3*COMP_WIDTH-1:0] lattice_origin_a;
  logic [3*COMP_WIDTH-1:0] vertex_b;
  logic [3*COMP_WIDTH-1:0] normal_b;
  logic [3*COMP_WIDTH-1:0] tangent_b;
  logic [3*COMP_WIDTH-1:0] bitangent_b;
  logic [3*COMP_WIDTH-1:0] lattice_origin_b;

  modport source (output valid, vertex_a, normal_a, tangent_a, bitangent_a, lattice_origin_a,
                  vertex_b, normal_b, tangent_b, bitangent_b, lattice_origin_b, input ready);
  modport sink (input valid, vertex_a, normal_a, tangent_a, bitangent_a, lattice_origin_a,
                vertex_b, normal_b, tangent_b, bitangent_b, lattice_origin_b, output ready);
endinterface

interface lopm_out_if import lopm_pkg::*;;
  logic valid;
  logic ready;
  logic signed [IDX_W-1:0] offset_a_u;
  logic signed [IDX_W-1:0] offset_a_v;
  logic signed [IDX_W-1:0] offset_b_u;
  logic signed [IDX_W-1:0] offset_b_v;
  logic [ERR_W-1:0] squared_error;

  modport source (output valid, offset_a_u, offset_a_v, offset_b_u, offset_b_v, squared_error,
                  input ready);
  modport sink (input valid, offset_a_u, offset_a_v, offset_b_u, offset_b_v, squared_error,
                output ready);
endinterface

FILE: rtl/lopm_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module lopm_div import lopm_pkg::*; #(
  parameter int NW    = 8,
  parameter int DW    = 8,
  parameter int QB    = 4,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  logic [NW-1:0]    num,
  input  logic [DW-1:0]    den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_v,
  output logic [QB-1:0]    quo,
  output div_stat_t        stat,
  output logic [TAG_W-1:0] tag_out
);

  logic [NW-1:0]    rem [QB+1];
  logic [QB-1:0]    qq  [QB+1];
  logic [DW-1:0]    dd  [QB+1];
  logic             vv  [QB+1];
  logic             oo  [QB+1];
  logic [TAG_W-1:0] tt  [QB+1];
  logic             fit [QB];

  always_ff @(posedge clk) begin
    if (rst) vv[0] <= 1'b0;
    else if (en) vv[0] <= in_v;
    if (en) begin
      rem[0] <= num;
      dd[0]  <= den;
      qq[0]  <= '0;
      // quotient would not fit in QB bits
      oo[0]  <= (num >> QB) >= NW'(den);
      tt[0]  <= tag_in;
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_stage
    localparam int SH = QB - 1 - g;
    assign fit[g] = (rem[g] >> SH) >= NW'(dd[g]);

    always_ff @(posedge clk) begin
      if (rst) vv[g+1] <= 1'b0;
      else if (en) vv[g+1] <= vv[g];
      if (en) begin
        rem[g+1] <= fit[g] ? rem[g] - (NW'(dd[g]) << SH) : rem[g];
        qq[g+1]  <= qq[g] | (fit[g] ? (QB'(1) << SH) : '0);
        dd[g+1]  <= dd[g];
        oo[g+1]  <= oo[g];
        tt[g+1]  <= tt[g];
      end
    end
  end

  assign out_v    = vv[QB];
  assign quo      = qq[QB];
  assign stat.ovf = oo[QB];
  assign stat.rnz = rem[QB] != '0;
  assign tag_out  = tt[QB];

endmodule

FILE: rtl/lattice_offset_pair_match.sv
// Lattice offset pair match: takes one edge per cycle while the output buffer is not full and
// returns one result per edge. The depth is set by two bit-per-stage divider pipelines: 42
// stages for the Lagrange multipliers (41 quotient bits) and 18 stages for the four lattice
// indices (17 quotient bits), plus arithmetic stages, a four-level argmin tree over the 16
// corner pairs and the output register. A two-entry output buffer lets one more edge enter
// while a result waits. lattice_scale is read live and must only be written while the block
// is idle; a scale of zero acts as one. There is no clearing pass after reset.
`include "assert_macros.svh"

module lattice_offset_pair_match import lopm_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  lopm_in_if.sink               item_in,
  lopm_out_if.source            item_out
);

  localparam int W     = COMP_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DOT_W = 2*W + 1;
  localparam int D_W   = 2*W + 2;
  localparam int CS_W  = F + 2;
  localparam int CS2_W = 2*CS_W;
  localparam int CSD_W = CS_W + D_W;
  localparam int NUM_W = 2*W + 5;
  localparam int DEN_W = 2*F + 2;
  localparam int LN_W  = NUM_W + F + 1;
  localparam int QL    = L_SAT_BITS + 1;
  localparam int L_W   = L_SAT_BITS + 2;
  localparam int PR_W  = W + L_W;
  localparam int QN_W  = W + L_W + 2;
  localparam int DA_W  = DA_SAT_BITS + 2;
  localparam int TP_W  = W + DA_W;
  localparam int IX_W  = TP_W + 2;
  localparam int QI    = IDX_W + 1;
  localparam int TU_W  = W + IDX_W;
  localparam int WW_W  = W + IDX_W + 2;
  localparam int SC_W  = SCALE_W + 1;
  localparam int WS_W  = WW_W + SC_W;
  localparam int CD_W  = WS_W + 2;
  localparam int DF_W  = DF_SAT_BITS + 2;
  localparam int SQ_W  = 2*DF_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int SH_IX = 2*F - SCALE_FRAC;
  localparam int VEC_W = 30*W;
  localparam int PSEL_W = $clog2(PAIRS);

  localparam longint EPS = ((64'sd1 <<< (2*F)) + 64'sd5000) / 64'sd10000;
  localparam logic signed [63:0] ONE_F  = 64'sd1 <<< F;
  localparam logic signed [63:0] LIM_DA = 64'sd1 <<< DA_SAT_BITS;
  localparam logic signed [63:0] LIM_DF = 64'sd1 <<< DF_SAT_BITS;
  localparam logic [QL:0] LIM_L = (QL+1)'(1) << L_SAT_BITS;
  localparam logic [QI:0] IDX_MAX = (QI+1)'((1 << (IDX_W-1)) - 1);
  localparam logic [QI:0] IDX_NEG = (QI+1)'(1 << (IDX_W-1));
  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  // vector slots of one edge
  localparam int V_PA = 0, V_NA = 1, V_TA = 2, V_BA = 3, V_OA = 4;
  localparam int V_PB = 5, V_NB = 6, V_TB = 7, V_BB = 8, V_OB = 9;

  typedef logic [9:0][2:0][W-1:0] vecs_t;

  typedef struct packed {
    logic signed [IDX_W-1:0] au;
    logic signed [IDX_W-1:0] av;
    logic signed [IDX_W-1:0] bu;
    logic signed [IDX_W-1:0] bv;
  } idx_t;

  typedef struct packed {
    logic signed [IDX_W-1:0] au;
    logic signed [IDX_W-1:0] av;
    logic signed [IDX_W-1:0] bu;
    logic signed [IDX_W-1:0] bv;
    logic [ERR_W-1:0]        err;
  } res_t;

  function automatic logic signed [DOT_W-1:0] dot3(input logic [2:0][W-1:0] a,
                                                   input logic [2:0][W-1:0] b);
    logic signed [DOT_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < 3; k++) acc = acc + DOT_W'($signed(a[k]) * $signed(b[k]));
    return acc;
  endfunction

  function automatic logic signed [L_W-1:0] sat_l(input logic [QL-1:0] q, input div_stat_t st,
                                                  input logic neg);
    logic [QL:0] mag;
    logic signed [L_W-1:0] r;
    mag = {1'b0, q} + (QL+1)'(st.rnz);
    if (neg) r = (st.ovf || mag > LIM_L) ? -L_W'(LIM_L) : -L_W'(mag);
    else r = (st.ovf || {1'b0, q} > LIM_L) ? L_W'(LIM_L) : L_W'(q);
    return r;
  endfunction

  function automatic logic signed [IDX_W-1:0] sat_i(input logic [QI-1:0] q, input div_stat_t st,
                                                    input logic neg);
    logic [QI:0] mag;
    logic signed [IDX_W-1:0] r;
    mag = {1'b0, q} + (QI+1)'(st.rnz);
    if (neg) r = (st.ovf || mag > IDX_NEG) ? -IDX_W'(IDX_NEG) : -IDX_W'(mag);
    else r = (st.ovf || {1'b0, q} > IDX_MAX) ? IDX_W'(IDX_MAX) : IDX_W'(q);
    return r;
  endfunction

  function automatic logic signed [IDX_W-1:0] bump(input logic signed [IDX_W-1:0] x,
                                                   input logic b);
    logic signed [IDX_W:0] s;
    s = (IDX_W+1)'(x) + (IDX_W+1)'({1'b0, b});
    return (s > $signed((IDX_W+1)'(IDX_MAX))) ? IDX_W'(IDX_MAX) : IDX_W'(s);
  endfunction

  // configuration register
  logic [SCALE_W-1:0] scale;
  logic [SCALE_W-1:0] s_eff;
  logic               reg_hit;

  assign reg_hit = paddr[APB_ADDR_W-1:2] == (APB_ADDR_W-2)'(REG_LATTICE_SCALE);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DATA_W'(scale) : '0;
  assign s_eff   = (scale == '0) ? SCALE_W'(1) : scale;

  always_ff @(posedge clk) begin
    if (rst) scale <= SCALE_RESET;
    else if (psel && penable && pwrite && reg_hit) scale <= pwdata[SCALE_W-1:0];
  end

  logic adv;

  // stage 1: input register
  logic  v1;
  vecs_t x1;
  vecs_t x_in;

  assign x_in[V_PA] = item_in.vertex_a;
  assign x_in[V_NA] = item_in.normal_a;
  assign x_in[V_TA] = item_in.tangent_a;
  assign x_in[V_BA] = item_in.bitangent_a;
  assign x_in[V_OA] = item_in.lattice_origin_a;
  assign x_in[V_PB] = item_in.vertex_b;
  assign x_in[V_NB] = item_in.normal_b;
  assign x_in[V_TB] = item_in.tangent_b;
  assign x_in[V_BB] = item_in.bitangent_b;
  assign x_in[V_OB] = item_in.lattice_origin_b;
  assign item_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= item_in.valid;
    if (adv) x1 <= x_in;
  end

  // stage 2: dot products
  logic v2;
  vecs_t x2;
  logic signed [DOT_W-1:0] dapa, dapb, dbpa, dbpb, dnn;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      x2   <= x1;
      dapa <= dot3(x1[V_NA], x1[V_PA]);
      dapb <= dot3(x1[V_NA], x1[V_PB]);
      dbpa <= dot3(x1[V_NB], x1[V_PA]);
      dbpb <= dot3(x1[V_NB], x1[V_PB]);
      dnn  <= dot3(x1[V_NA], x1[V_NB]);
    end
  end

  // stage 3: plane offsets and clamped cosine
  logic v3;
  vecs_t x3;
  logic signed [D_W-1:0] d0_3, d1_3;
  logic signed [CS_W-1:0] cs3;
  logic signed [DOT_W-1:0] cs_raw;

  assign cs_raw = dnn >>> F;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      x3   <= x2;
      d0_3 <= D_W'(dapb) - D_W'(dapa);
      d1_3 <= D_W'(dbpa) - D_W'(dbpb);
      if (cs_raw > ONE_F) cs3 <= CS_W'(ONE_F);
      else if (cs_raw < -ONE_F) cs3 <= -CS_W'(ONE_F);
      else cs3 <= CS_W'(cs_raw);
    end
  end

  // stage 4: cosine products
  logic v4;
  vecs_t x4;
  logic signed [D_W-1:0] d0_4, d1_4;
  logic signed [CS2_W-1:0] cs2;
  logic signed [CSD_W-1:0] csd0, csd1;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      x4   <= x3;
      d0_4 <= d0_3;
      d1_4 <= d1_3;
      cs2  <= CS2_W'(cs3) * CS2_W'(cs3);
      csd0 <= CSD_W'(cs3) * CSD_W'(d0_3);
      csd1 <= CSD_W'(cs3) * CSD_W'(d1_3);
    end
  end

  // multiplier division setup
  logic signed [63:0] den_s;
  logic [DEN_W-1:0] den;
  logic signed [NUM_W-1:0] num0, num1;
  logic [NUM_W-1:0] mag0, mag1;
  logic [LN_W-1:0] dvd0, dvd1;

  always_comb begin
    den_s = (64'sd1 <<< (2*F)) - 64'(cs2) + EPS;
    den   = den_s[DEN_W-1:0];
    num0  = NUM_W'(d0_4) - NUM_W'(csd1 >>> F);
    num1  = NUM_W'(d1_4) - NUM_W'(csd0 >>> F);
    mag0  = num0[NUM_W-1] ? $unsigned(-num0) : $unsigned(num0);
    mag1  = num1[NUM_W-1] ? $unsigned(-num1) : $unsigned(num1);
    dvd0  = LN_W'(mag0) << (F+1);
    dvd1  = LN_W'(mag1) << (F+1);
  end

  logic vl0, vl1;
  logic [QL-1:0] ql0, ql1;
  div_stat_t stl0, stl1;
  logic [VEC_W:0] tl0;
  logic tl1;

  lopm_div #(.NW(LN_W), .DW(DEN_W), .QB(QL), .TAG_W(VEC_W+1)) u_div_l0 (
    .clk(clk), .rst(rst), .en(adv), .in_v(v4), .num(dvd0), .den(den),
    .tag_in({x4, num0[NUM_W-1]}), .out_v(vl0), .quo(ql0), .stat(stl0), .tag_out(tl0)
  );

  lopm_div #(.NW(LN_W), .DW(DEN_W), .QB(QL), .TAG_W(1)) u_div_l1 (
    .clk(clk), .rst(rst), .en(adv), .in_v(v4), .num(dvd1), .den(den),
    .tag_in(num1[NUM_W-1]), .out_v(vl1), .quo(ql1), .stat(stl1), .tag_out(tl1)
  );

  // stage: saturated multipliers
  logic v6;
  vecs_t x6;
  logic signed [L_W-1:0] l0, l1;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= vl0 && vl1;
    if (adv) begin
      x6 <= tl0[VEC_W:1];
      l0 <= sat_l(ql0, stl0, tl0[0]);
      l1 <= sat_l(ql1, stl1, tl1);
    end
  end

  // stage: normal times multiplier
  logic v7;
  vecs_t x7;
  logic signed [PR_W-1:0] nal [3];
  logic signed [PR_W-1:0] nbl [3];

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (adv) v7 <= v6;
    if (adv) begin
      x7 <= x6;
      for (int k = 0; k < 3; k++) begin
        nal[k] <= PR_W'($signed(x6[V_NA][k])) * PR_W'(l0);
        nbl[k] <= PR_W'($signed(x6[V_NB][k])) * PR_W'(l1);
      end
    end
  end

  // stage: meeting point relative to each origin
  logic v8;
  vecs_t x8;
  logic signed [DA_W-1:0] da [3];
  logic signed [DA_W-1:0] db [3];
  logic signed [QN_W-1:0] qn [3];
  logic signed [QN_W:0] ra [3];
  logic signed [QN_W:0] rb [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qn[k] = ((QN_W'($signed(x7[V_PA][k])) + QN_W'($signed(x7[V_PB][k]))) <<< (F+1))
            - QN_W'(nal[k]) - QN_W'(nbl[k]);
      qn[k] = qn[k] >>> (F+2);
      ra[k] = (QN_W+1)'(qn[k]) - (QN_W+1)'($signed(x7[V_OA][k]));
      rb[k] = (QN_W+1)'(qn[k]) - (QN_W+1)'($signed(x7[V_OB][k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (adv) v8 <= v7;
    if (adv) begin
      x8 <= x7;
      for (int k = 0; k < 3; k++) begin
        if (ra[k] > LIM_DA) da[k] <= DA_W'(LIM_DA);
        else if (ra[k] < -LIM_DA) da[k] <= -DA_W'(LIM_DA);
        else da[k] <= DA_W'(ra[k]);
        if (rb[k] > LIM_DA) db[k] <= DA_W'(LIM_DA);
        else if (rb[k] < -LIM_DA) db[k] <= -DA_W'(LIM_DA);
        else db[k] <= DA_W'(rb[k]);
      end
    end
  end

  // stage: tangent projection products (au, av, bu, bv)
  logic v9;
  vecs_t x9;
  logic signed [TP_W-1:0] tp [4][3];

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (adv) v9 <= v8;
    if (adv) begin
      x9 <= x8;
      for (int k = 0; k < 3; k++) begin
        tp[0][k] <= TP_W'($signed(x8[V_TA][k])) * TP_W'(da[k]);
        tp[1][k] <= TP_W'($signed(x8[V_BA][k])) * TP_W'(da[k]);
        tp[2][k] <= TP_W'($signed(x8[V_TB][k])) * TP_W'(db[k]);
        tp[3][k] <= TP_W'($signed(x8[V_BB][k])) * TP_W'(db[k]);
      end
    end
  end

  // index division setup: floor by 2^(2F-12) first, then by the scale
  logic signed [IX_W-1:0] ps [4];
  logic [IX_W-1:0] pm [4];
  logic pn [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ps[j] = (IX_W'(tp[j][0]) + IX_W'(tp[j][1]) + IX_W'(tp[j][2])) >>> SH_IX;
      pn[j] = ps[j][IX_W-1];
      pm[j] = pn[j] ? $unsigned(-ps[j]) : $unsigned(ps[j]);
    end
  end

  logic vi [4];
  logic [QI-1:0] qi [4];
  div_stat_t sti [4];
  logic [VEC_W:0] ti0;
  logic ti1, ti2, ti3;

  lopm_div #(.NW(IX_W), .DW(SCALE_W), .QB(QI), .TAG_W(VEC_W+1)) u_div_au (
    .clk(clk), .rst(rst), .en(adv), .in_v(v9), .num(pm[0]), .den(s_eff),
    .tag_in({x9, pn[0]}), .out_v(vi[0]), .quo(qi[0]), .stat(sti[0]), .tag_out(ti0)
  );

  lopm_div #(.NW(IX_W), .DW(SCALE_W), .QB(QI), .TAG_W(1)) u_div_av (
    .clk(clk), .rst(rst), .en(adv), .in_v(v9), .num(pm[1]), .den(s_eff),
    .tag_in(pn[1]), .out_v(vi[1]), .quo(qi[1]), .stat(sti[1]), .tag_out(ti1)
  );

  lopm_div #(.NW(IX_W), .DW(SCALE_W), .QB(QI), .TAG_W(1)) u_div_bu (
    .clk(clk), .rst(rst), .en(adv), .in_v(v9), .num(pm[2]), .den(s_eff),
    .tag_in(pn[2]), .out_v(vi[2]), .quo(qi[2]), .stat(sti[2]), .tag_out(ti2)
  );

  lopm_div #(.NW(IX_W), .DW(SCALE_W), .QB(QI), .TAG_W(1)) u_div_bv (
    .clk(clk), .rst(rst), .en(adv), .in_v(v9), .num(pm[3]), .den(s_eff),
    .tag_in(pn[3]), .out_v(vi[3]), .quo(qi[3]), .stat(sti[3]), .tag_out(ti3)
  );

  // stage: saturated floor indices
  logic v10;
  vecs_t x10;
  idx_t ix10;

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (adv) v10 <= vi[0] && vi[1] && vi[2] && vi[3];
    if (adv) begin
      x10     <= ti0[VEC_W:1];
      ix10.au <= sat_i(qi[0], sti[0], ti0[0]);
      ix10.av <= sat_i(qi[1], sti[1], ti1);
      ix10.bu <= sat_i(qi[2], sti[2], ti2);
      ix10.bv <= sat_i(qi[3], sti[3], ti3);
    end
  end

  // stage: tangent times index
  logic v11;
  vecs_t x11;
  idx_t ix11;
  logic signed [TU_W-1:0] tu [2][3];
  logic signed [TU_W-1:0] bw [2][3];

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (adv) v11 <= v10;
    if (adv) begin
      x11  <= x10;
      ix11 <= ix10;
      for (int k = 0; k < 3; k++) begin
        tu[0][k] <= TU_W'($signed(x10[V_TA][k])) * TU_W'(ix10.au);
        bw[0][k] <= TU_W'($signed(x10[V_BA][k])) * TU_W'(ix10.av);
        tu[1][k] <= TU_W'($signed(x10[V_TB][k])) * TU_W'(ix10.bu);
        bw[1][k] <= TU_W'($signed(x10[V_BB][k])) * TU_W'(ix10.bv);
      end
    end
  end

  // stage: corner offsets in tangent units, corner bit 0 steps u, bit 1 steps v
  logic v12;
  vecs_t x12;
  idx_t ix12;
  logic signed [WW_W-1:0] cw [2][CORNERS][3];

  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (adv) v12 <= v11;
    if (adv) begin
      x12  <= x11;
      ix12 <= ix11;
      for (int i = 0; i < CORNERS; i++) begin
        for (int k = 0; k < 3; k++) begin
          cw[0][i][k] <= WW_W'(tu[0][k]) + WW_W'(bw[0][k])
                       + (i[0] ? WW_W'($signed(x11[V_TA][k])) : '0)
                       + (i[1] ? WW_W'($signed(x11[V_BA][k])) : '0);
          cw[1][i][k] <= WW_W'(tu[1][k]) + WW_W'(bw[1][k])
                       + (i[0] ? WW_W'($signed(x11[V_TB][k])) : '0)
                       + (i[1] ? WW_W'($signed(x11[V_BB][k])) : '0);
        end
      end
    end
  end

  // stage: scaled corner offsets
  logic v13;
  vecs_t x13;
  idx_t ix13;
  logic signed [WS_W-1:0] ws [2][CORNERS][3];

  always_ff @(posedge clk) begin
    if (rst) v13 <= 1'b0;
    else if (adv) v13 <= v12;
    if (adv) begin
      x13  <= x12;
      ix13 <= ix12;
      for (int sd = 0; sd < 2; sd++)
        for (int i = 0; i < CORNERS; i++)
          for (int k = 0; k < 3; k++)
            ws[sd][i][k] <= WS_W'(cw[sd][i][k]) * WS_W'($signed({1'b0, s_eff}));
    end
  end

  // stage: corner differences, floored to QF and clamped
  logic v14;
  idx_t ix14;
  logic signed [DF_W-1:0] df [PAIRS][3];
  logic signed [CD_W-1:0] dr [PAIRS][3];

  always_comb begin
    for (int p = 0; p < PAIRS; p++)
      for (int k = 0; k < 3; k++) begin
        dr[p][k] = ((CD_W'($signed(x13[V_OA][k])) - CD_W'($signed(x13[V_OB][k])))
                     <<< SCALE_FRAC)
                 + CD_W'(ws[0][p/CORNERS][k]) - CD_W'(ws[1][p%CORNERS][k]);
        dr[p][k] = dr[p][k] >>> SCALE_FRAC;
      end
  end

  always_ff @(posedge clk) begin
    if (rst) v14 <= 1'b0;
    else if (adv) v14 <= v13;
    if (adv) begin
      ix14 <= ix13;
      for (int p = 0; p < PAIRS; p++)
        for (int k = 0; k < 3; k++) begin
          if (dr[p][k] > LIM_DF) df[p][k] <= DF_W'(LIM_DF);
          else if (dr[p][k] < -LIM_DF) df[p][k] <= -DF_W'(LIM_DF);
          else df[p][k] <= DF_W'(dr[p][k]);
        end
    end
  end

  // stage: squares
  logic v15;
  idx_t ix15;
  logic [SQ_W-1:0] sq [PAIRS][3];

  always_ff @(posedge clk) begin
    if (rst) v15 <= 1'b0;
    else if (adv) v15 <= v14;
    if (adv) begin
      ix15 <= ix14;
      for (int p = 0; p < PAIRS; p++)
        for (int k = 0; k < 3; k++)
          sq[p][k] <= $unsigned(SQ_W'(df[p][k]) * SQ_W'(df[p][k]));
    end
  end

  // stage: pair costs, then argmin tree, lower pair wins ties
  logic [SUM_W-1:0] csum [PAIRS];
  logic [ERR_W-1:0] tc [5][PAIRS];
  logic [PSEL_W-1:0] tsel [5][PAIRS];
  logic tv [5];
  idx_t tix [5];

  always_comb begin
    for (int p = 0; p < PAIRS; p++)
      csum[p] = (SUM_W'(sq[p][0]) + SUM_W'(sq[p][1]) + SUM_W'(sq[p][2])) >> F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < 5; l++) tv[l] <= 1'b0;
    end else if (adv) begin
      tv[0] <= v15;
      for (int l = 1; l < 5; l++) tv[l] <= tv[l-1];
    end
    if (adv) begin
      tix[0] <= ix15;
      for (int p = 0; p < PAIRS; p++) begin
        tc[0][p]   <= (csum[p] > SUM_W'(ERR_MAX)) ? ERR_MAX : csum[p][ERR_W-1:0];
        tsel[0][p] <= PSEL_W'(p);
      end
      for (int l = 1; l < 5; l++) begin
        tix[l] <= tix[l-1];
        for (int e = 0; e < (PAIRS >> l); e++) begin
          if (tc[l-1][2*e+1] < tc[l-1][2*e]) begin
            tc[l][e]   <= tc[l-1][2*e+1];
            tsel[l][e] <= tsel[l-1][2*e+1];
          end else begin
            tc[l][e]   <= tc[l-1][2*e];
            tsel[l][e] <= tsel[l-1][2*e];
          end
        end
      end
    end
  end

  // result and output buffer
  res_t res, out_r, skid_r;
  logic out_v, skid_v;
  logic [PSEL_W-1:0] best;

  assign best    = tsel[4][0];
  assign res.au  = bump(tix[4].au, best[2]);
  assign res.av  = bump(tix[4].av, best[3]);
  assign res.bu  = bump(tix[4].bu, best[0]);
  assign res.bv  = bump(tix[4].bv, best[1]);
  assign res.err = tc[4][0];
  assign adv     = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && !item_out.ready) begin
      if (tv[4] && adv) skid_v <= 1'b1;
    end else if (skid_v) begin
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_v <= tv[4];
    end
    if (out_v && !item_out.ready) begin
      if (adv) skid_r <= res;
    end else if (skid_v) begin
      out_r <= skid_r;
    end else begin
      out_r <= res;
    end
  end

  assign item_out.valid         = out_v;
  assign item_out.offset_a_u    = out_r.au;
  assign item_out.offset_a_v    = out_r.av;
  assign item_out.offset_b_u    = out_r.bu;
  assign item_out.offset_b_v    = out_r.bv;
  assign item_out.squared_error = out_r.err;

  // the buffer only fills behind a waiting result
  `ASSERT_ALWAYS(a_skid_behind_out, clk, rst, !skid_v || out_v)
  `ASSERT_NEXT(a_skid_drains, clk, rst, skid_v && item_out.ready, !skid_v && out_v)
  `ASSERT_NEXT(a_skid_fill, clk, rst, !skid_v && out_v && !item_out.ready && tv[4], skid_v)
  `ASSERT_NEXT(a_stall_freeze, clk, rst, skid_v && !item_out.ready, skid_v && $stable(tv[4]))

endmodule

FILE: verif/lattice_offset_pair_match_checker.sv
// checker for the lattice offset pair match block: predicts each result and compares it
module lattice_offset_pair_match_checker import lopm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  lopm_in_if                    in_ch,
  lopm_out_if                   out_ch,
  output int                    failures,
  output int                    pending
);

  localparam int W = COMP_WIDTH_DEF;
  localparam int F = FRAC_BITS_DEF;
  localparam longint ONE_F = longint'(1) << F;
  localparam longint EPS = ((longint'(1) << (2 * F)) + 5000) / 10000;
  localparam longint LIM40 = longint'(1) << 40;
  localparam longint LIM30 = longint'(1) << 30;
  localparam longint ERR_MAX = (longint'(1) << 40) - 1;

  typedef struct packed {
    logic [IDX_W-1:0] a_u;
    logic [IDX_W-1:0] a_v;
    logic [IDX_W-1:0] b_u;
    logic [IDX_W-1:0] b_v;
    logic [ERR_W-1:0] err;
  } match_t;

  typedef longint vec_t [3];

  logic [SCALE_W-1:0] scale;
  match_t             match_q[$];

  assign pending = match_q.size();

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic longint sat(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic vec_t split3(logic [3*W-1:0] w);
    vec_t v;
    for (int k = 0; k < 3; k++) v[k] = longint'($signed(w[k*W +: W]));
    return v;
  endfunction

  function automatic longint dot(vec_t a, vec_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic match_t best_offsets(logic [3*W-1:0] f [10], logic [SCALE_W-1:0] sc);
    vec_t pa, na, ta, ba, oa, pb, nb, tb, bb, ob, da, db;
    vec_t ca [CORNERS];
    vec_t cb [CORNERS];
    longint s, d0, d1, cs, den, num0, num1, l0, l1, n, q, div, au, av, bu, bv, d;
    logic [63:0] sum, cost, best;
    int bi, bj;
    match_t r;
    pa = split3(f[0]); na = split3(f[1]); ta = split3(f[2]); ba = split3(f[3]);
    oa = split3(f[4]); pb = split3(f[5]); nb = split3(f[6]); tb = split3(f[7]);
    bb = split3(f[8]); ob = split3(f[9]);
    s = (sc == 0) ? 1 : longint'(sc);
    d0 = dot(na, pb) - dot(na, pa);
    d1 = dot(nb, pa) - dot(nb, pb);
    cs = sat(floor_div(dot(na, nb), ONE_F), -ONE_F, ONE_F);
    den = (longint'(1) << (2 * F)) - cs * cs + EPS;
    num0 = d0 - floor_div(cs * d1, ONE_F);
    num1 = d1 - floor_div(cs * d0, ONE_F);
    l0 = sat(floor_div(num0 * (ONE_F * 2), den), -LIM40, LIM40);
    l1 = sat(floor_div(num1 * (ONE_F * 2), den), -LIM40, LIM40);
    for (int k = 0; k < 3; k++) begin
      n = (pa[k] + pb[k]) * (ONE_F * 2) - (na[k] * l0 + nb[k] * l1);
      q = floor_div(n, ONE_F * 4);
      da[k] = sat(q - oa[k], -LIM40, LIM40);
      db[k] = sat(q - ob[k], -LIM40, LIM40);
    end
    div = s * (longint'(1) << (2 * F - SCALE_FRAC));
    au = sat(floor_div(dot(ta, da), div), -32768, 32767);
    av = sat(floor_div(dot(ba, da), div), -32768, 32767);
    bu = sat(floor_div(dot(tb, db), div), -32768, 32767);
    bv = sat(floor_div(dot(bb, db), div), -32768, 32767);
    // corners kept exact at F+12 fraction bits
    for (int i = 0; i < CORNERS; i++) begin
      for (int k = 0; k < 3; k++) begin
        ca[i][k] = oa[k] * (longint'(1) << SCALE_FRAC)
                 + (ta[k] * (au + (i & 1)) + ba[k] * (av + ((i >> 1) & 1))) * s;
        cb[i][k] = ob[k] * (longint'(1) << SCALE_FRAC)
                 + (tb[k] * (bu + (i & 1)) + bb[k] * (bv + ((i >> 1) & 1))) * s;
      end
    end
    best = '1;
    bi = 0;
    bj = 0;
    for (int i = 0; i < CORNERS; i++) begin
      for (int j = 0; j < CORNERS; j++) begin
        sum = 0;
        for (int k = 0; k < 3; k++) begin
          d = sat(floor_div(ca[i][k] - cb[j][k], longint'(1) << SCALE_FRAC), -LIM30, LIM30);
          sum += d * d;
        end
        cost = sum >> F;
        if (cost > ERR_MAX) cost = ERR_MAX;
        // strict compare keeps the first least pair
        if (cost < best) begin
          best = cost;
          bi = i;
          bj = j;
        end
      end
    end
    r.a_u = IDX_W'(sat(au + (bi & 1), -32768, 32767));
    r.a_v = IDX_W'(sat(av + ((bi >> 1) & 1), -32768, 32767));
    r.b_u = IDX_W'(sat(bu + (bj & 1), -32768, 32767));
    r.b_v = IDX_W'(sat(bv + ((bj >> 1) & 1), -32768, 32767));
    r.err = best[ERR_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == APB_ADDR_W'(REG_LATTICE_SCALE * 4)) begin
      scale <= pwdata[SCALE_W-1:0];
    end
  end

  initial failures = 0;

  always @(posedge clk) begin
    logic [3*W-1:0] f [10];
    match_t want;
    if (!rst && in_ch.valid && in_ch.ready) begin
      f[0] = in_ch.vertex_a;  f[1] = in_ch.normal_a;  f[2] = in_ch.tangent_a;
      f[3] = in_ch.bitangent_a; f[4] = in_ch.lattice_origin_a;
      f[5] = in_ch.vertex_b;  f[6] = in_ch.normal_b;  f[7] = in_ch.tangent_b;
      f[8] = in_ch.bitangent_b; f[9] = in_ch.lattice_origin_b;
      match_q.push_back(best_offsets(f, scale));
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (match_q.size() == 0) begin
        failures++;
        $display("%0t result with nothing expected: %0h %0h %0h %0h %0h", $time,
                 out_ch.offset_a_u, out_ch.offset_a_v, out_ch.offset_b_u,
                 out_ch.offset_b_v, out_ch.squared_error);
      end else begin
        want = match_q.pop_front();
        check_field("offset_a_u", want.a_u, $unsigned(out_ch.offset_a_u));
        check_field("offset_a_v", want.a_v, $unsigned(out_ch.offset_a_v));
        check_field("offset_b_u", want.b_u, $unsigned(out_ch.offset_b_u));
        check_field("offset_b_v", want.b_v, $unsigned(out_ch.offset_b_v));
        check_field("squared_error", want.err, out_ch.squared_error);
      end
    end
  end

endmodule

FILE: verif/lattice_offset_pair_match_tb.sv
// testbench top of the lattice offset pair match block: stimulus, config writes and verdict
module lattice_offset_pair_match_tb;
  import lopm_pkg::*;

  localparam int W = COMP_WIDTH_DEF;
  localparam int SETTLE = 120;

  typedef logic [3*W-1:0] field_t;
  typedef struct {
    field_t f [10];
  } pair_item_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    failures;
  int                    pending;
  bit                    no_idle;
  bit                    stall_req;

  lopm_in_if  in_ch ();
  lopm_out_if out_ch ();

  lattice_offset_pair_match dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .item_in(in_ch), .item_out(out_ch)
  );

  lattice_offset_pair_match_checker checker_i (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_ch(in_ch), .out_ch(out_ch), .failures(failures), .pending(pending)
  );

  initial clk = 0;
  always #6 clk = ~clk;

  initial begin
    #(12 * 400000);
    $display("lattice_offset_pair_match: mismatch");
    $finish;
  end

  function automatic field_t pack3(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] z);
    return {z, y, x};
  endfunction

  // component in a chosen class: full range, small coordinate, or unit-like
  function automatic logic [W-1:0] comp(int kind);
    int r;
    case (kind)
      0: return W'($urandom);
      1: return W'($signed($urandom_range(0, 32768)) - 16384);
      default: begin
        r = $urandom_range(0, 5);
        if (r == 0) return W'(0);
        if (r == 1) return W'(4096);
        if (r == 2) return W'(-4096);
        return W'(int'($urandom_range(0, 8192)) - 4096);
      end
    endcase
  endfunction

  function automatic field_t vec(int kind);
    return pack3(comp(kind), comp(kind), comp(kind));
  endfunction

  function automatic pair_item_t random_pair();
    pair_item_t it;
    bit wild;
    wild = ($urandom_range(0, 99) < 25);
    for (int i = 0; i < 10; i++) begin
      if (wild) it.f[i] = vec($urandom_range(0, 2));
      else if (i % 5 == 0 || i % 5 == 4) it.f[i] = vec(1);
      else it.f[i] = vec(2);
    end
    return it;
  endfunction

  function automatic pair_item_t same_pair(field_t v);
    pair_item_t it;
    for (int i = 0; i < 10; i++) it.f[i] = v;
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_pair(pair_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.vertex_a         <= it.f[0];
    in_ch.normal_a         <= it.f[1];
    in_ch.tangent_a        <= it.f[2];
    in_ch.bitangent_a      <= it.f[3];
    in_ch.lattice_origin_a <= it.f[4];
    in_ch.vertex_b         <= it.f[5];
    in_ch.normal_b         <= it.f[6];
    in_ch.tangent_b        <= it.f[7];
    in_ch.bitangent_b      <= it.f[8];
    in_ch.lattice_origin_b <= it.f[9];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    // let the checker count the last accepted item before pending is polled
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(REG_LATTICE_SCALE * 4);
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, one long hold on request
  initial begin
    int r;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_ch.ready <= 1'b0;
        stall_req = 0;
        repeat (400) @(posedge clk);
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r >= 97) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(15, 50)) @(posedge clk);
        end else begin
          out_ch.ready <= (r < 70);
        end
      end
    end
  end

  initial begin
    logic [SCALE_W-1:0] scales [5];
    pair_item_t it;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    no_idle = 0;
    stall_req = 0;
    in_ch.valid = 1'b0;
    in_ch.vertex_a = '0; in_ch.normal_a = '0; in_ch.tangent_a = '0;
    in_ch.bitangent_a = '0; in_ch.lattice_origin_a = '0;
    in_ch.vertex_b = '0; in_ch.normal_b = '0; in_ch.tangent_b = '0;
    in_ch.bitangent_b = '0; in_ch.lattice_origin_b = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zeros, all ones, component extremes
    send_pair(same_pair('0));
    send_pair(same_pair('1));
    send_pair(same_pair(pack3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF)));
    send_pair(same_pair(pack3(20'h80000, 20'h80000, 20'h80000)));
    send_pair(same_pair(pack3(20'h80000, 20'h7FFFF, 20'h00001)));
    // normals far beyond unit length push cos past its clamp
    it = random_pair();
    it.f[1] = pack3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
    it.f[6] = pack3(20'h80000, 20'h80000, 20'h80000);
    send_pair(it);
    it.f[6] = it.f[1];
    send_pair(it);
    // parallel unit normals with offset planes give huge multipliers
    it = random_pair();
    it.f[1] = pack3(20'd0, 20'd0, 20'd4096);
    it.f[6] = pack3(20'd0, 20'd0, 20'd4096);
    it.f[0] = pack3(20'd0, 20'd0, 20'h7FFFF);
    it.f[5] = pack3(20'd0, 20'd0, 20'h80000);
    send_pair(it);
    // far origin and long tangents saturate the indices
    it = random_pair();
    it.f[4] = pack3(20'h80000, 20'h80000, 20'h80000);
    it.f[9] = pack3(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
    it.f[2] = pack3(20'h7FFFF, 20'd0, 20'd0);
    it.f[7] = pack3(20'h80000, 20'd0, 20'd0);
    send_pair(it);
    for (int i = 0; i < 8; i++) send_pair(random_pair());

    scales[0] = 20'd4096;
    scales[1] = 20'd1;
    scales[2] = 20'hFFFFF;
    scales[3] = 20'd0;
    scales[4] = SCALE_W'($urandom_range(1, 20000));
    for (int p = 0; p < 5; p++) begin
      drain();
      write_scale(scales[p]);
      no_idle = (p == 3);
      for (int i = 0; i < 160; i++) begin
        if (p == 1 && i == 40) stall_req = 1;
        if (p == 2 && i == 60) begin
          in_ch.valid <= 1'b0;
          while (pending != 0) @(posedge clk);
        end
        send_pair(random_pair());
      end
    end
    drain();

    if (failures == 0) begin
      $display("lattice_offset_pair_match: match");
    end else begin
      $display("lattice_offset_pair_match: mismatch");
    end
    $finish;
  end

endmodule
